@@ design/assert_macros.svh @@
// Assertion macros for the formatter core module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(name, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, expr)
`define ASSERT_NEXT(name, ante, cons)
`endif
`endif

@@ design/ifmt_pkg.sv @@
// Types, constants and helpers for the integer field formatter.
package ifmt_pkg;

    localparam int MAX_FIELD_DEF = 63;
    localparam int OUT_LIMIT     = 64;
    localparam int NDIG_MAX      = 24;

    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_UDEC = 3'd1;
    localparam logic [2:0] KIND_OCT  = 3'd2;
    localparam logic [2:0] KIND_HEXL = 3'd3;
    localparam logic [2:0] KIND_HEXU = 3'd4;

    localparam logic [1:0] SIZE_32 = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;

    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_OCT = 5'd8;
    localparam logic [4:0] BASE_HEX = 5'd16;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_A_UP  = 8'd65;
    localparam logic [7:0] CH_A_LO  = 8'd97;
    localparam logic [7:0] CH_X_UP  = 8'd88;
    localparam logic [7:0] CH_X_LO  = 8'd120;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PLAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       start;
        logic [4:0] base;
    } div_ctrl_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d >= 4'd10)
            c = (upper ? CH_A_UP : CH_A_LO) + {4'd0, d} - 8'd10;
        else
            c = CH_ZERO + {4'd0, d};
        return c;
    endfunction

endpackage

@@ design/ifmt_divider.sv @@
// Iterative divider: 64-bit value by a small base, eight quotient bits a cycle.
module ifmt_divider
    import ifmt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_ctrl_t   ctrl,
    input  logic [63:0] dividend,
    output logic        done,
    output logic [63:0] quotient,
    output logic [3:0]  remainder
);

    logic [63:0] work_reg, work_next;
    logic [3:0]  rem_reg, rem_next;
    logic [4:0]  base_reg, base_next;
    logic [2:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb
    begin
        logic [63:0] w;
        logic [3:0]  r;
        logic [4:0]  t;
        logic        q;
        w = work_reg;
        r = rem_reg;
        for (int i = 0; i < 8; i++)
        begin
            t = {r, w[63]};
            q = (t >= base_reg);
            r = q ? 4'(t - base_reg) : t[3:0];
            w = {w[62:0], q};
        end
        work_next = work_reg;
        rem_next  = rem_reg;
        base_next = base_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            work_next = dividend;
            rem_next  = 4'd0;
            base_next = ctrl.base;
            step_next = 3'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            work_next = w;
            rem_next  = r;
            step_next = step_reg + 3'd1;
            if (step_reg == 3'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        base_reg <= base_next;
    end

    assign done      = done_reg;
    assign quotient  = work_reg;
    assign remainder = rem_reg;

endmodule

@@ design/integer_field_formatter_core.sv @@
// Top level: sequencer, digit store and character output of the formatter.
//
//  channel | direction | payload
//  s_*     | in        | one conversion request
//  m_*     | out       | one ASCII character, tlast on the final one
//
// A valid item passes through accept, a prepare step, then per digit a launch of the
// divider (eight quotient bits a cycle) and a store of the digit, then a plan step,
// then one output character per cycle while m_tready allows; an invalid kind goes
// straight to output. s_tready is high only in the idle state.
// Reset clears the sequencer, the digit count and the output valid; no clearing pass.
// A stalled output holds the character and the sequencer waits.
module integer_field_formatter_core
    import ifmt_pkg::*;
#(
    parameter int MAX_FIELD = MAX_FIELD_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // value[63:0], size_mode[65:64], left_align[66], force_sign[67],
    // space_sign[68], zero_pad[69], alternate[70], field_width[76:71],
    // has_precision[77], min_digits[83:78], bits [87:84] unused
    input  logic [87:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // char_out[7:0]
    output logic [7:0]  m_tdata,
    // char_valid[0]
    output logic        m_tuser,
    output logic        m_tlast
);

    `include "assert_macros.svh"

    localparam int CW    = $clog2(MAX_FIELD + 25);
    localparam int POS_W = $clog2(OUT_LIMIT);
    localparam int DIG_W = $clog2(NDIG_MAX);
    localparam logic [CW-1:0] MAXF = CW'(MAX_FIELD);

    state_t state_reg, state_next;

    logic [2:0]    kind_reg, kind_next;
    logic [63:0]   mag_reg, mag_next;
    logic [1:0]    size_reg, size_next;
    logic          left_reg, left_next;
    logic          fsign_reg, fsign_next;
    logic          ssign_reg, ssign_next;
    logic          zpad_reg, zpad_next;
    logic          alt_reg, alt_next;
    logic          hasp_reg, hasp_next;
    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] prec_reg, prec_next;
    logic          neg_reg, neg_next;
    logic          nz_reg, nz_next;
    logic          zfirst_reg, zfirst_next;
    logic          empty_reg, empty_next;
    logic [DIG_W-1:0] ndig_reg, ndig_next;
    logic [DIG_W-1:0] dptr_reg, dptr_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]    pre0_reg, pre0_next;
    logic [7:0]    pre1_reg, pre1_next;
    logic [CW-1:0] e1_reg, e1_next, e2_reg, e2_next;
    logic [CW-1:0] e4_reg, e4_next, e5_reg, e5_next, e6_reg, e6_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [7:0]    m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg, m_tuser_next;
    logic          m_tlast_reg, m_tlast_next;

    logic [7:0]    dig_reg [NDIG_MAX];
    logic          dig_we;
    logic [7:0]    dig_char;

    div_ctrl_t     div_ctrl;
    logic          div_done;
    logic [63:0]   div_quot;
    logic [3:0]    div_rem;

    ifmt_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (mag_reg),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign dig_char = digit_char(div_rem, kind_reg == KIND_HEXU);

    always_comb
    begin
        logic [63:0]   masked;
        logic          sbit;
        logic [CW-1:0] fw, pr, ndw, zeros, plen, body, pad, s1, s3, s6, pw;
        logic          zp;
        masked = 64'd0;
        sbit = 1'b0;
        fw = '0; pr = '0; ndw = '0; zeros = '0; plen = '0; body = '0; pad = '0;
        s1 = '0; s3 = '0; s6 = '0; pw = '0; zp = 1'b0;

        state_next  = state_reg;
        kind_next   = kind_reg;
        mag_next    = mag_reg;
        size_next   = size_reg;
        left_next   = left_reg;
        fsign_next  = fsign_reg;
        ssign_next  = ssign_reg;
        zpad_next   = zpad_reg;
        alt_next    = alt_reg;
        hasp_next   = hasp_reg;
        width_next  = width_reg;
        prec_next   = prec_reg;
        neg_next    = neg_reg;
        nz_next     = nz_reg;
        zfirst_next = zfirst_reg;
        empty_next  = empty_reg;
        ndig_next   = ndig_reg;
        dptr_next   = dptr_reg;
        pos_next    = pos_reg;
        pre0_next   = pre0_reg;
        pre1_next   = pre1_reg;
        e1_next = e1_reg; e2_next = e2_reg;
        e4_next = e4_reg; e5_next = e5_reg; e6_next = e6_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        dig_we = 1'b0;
        div_ctrl.start = 1'b0;
        div_ctrl.base  = (kind_reg == KIND_SDEC || kind_reg == KIND_UDEC) ? BASE_DEC :
                         (kind_reg == KIND_OCT) ? BASE_OCT : BASE_HEX;
        s_tready = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    fw = CW'(s_tdata[76:71]);
                    pr = CW'(s_tdata[83:78]);
                    kind_next  = s_tuser;
                    mag_next   = s_tdata[63:0];
                    size_next  = s_tdata[65:64];
                    left_next  = s_tdata[66];
                    fsign_next = s_tdata[67];
                    ssign_next = s_tdata[68];
                    zpad_next  = s_tdata[69];
                    alt_next   = s_tdata[70];
                    width_next = (fw > MAXF) ? MAXF : fw;
                    hasp_next  = s_tdata[77];
                    prec_next  = (pr > MAXF) ? MAXF : pr;
                    ndig_next  = '0;
                    pos_next   = '0;
                    empty_next = (s_tuser > KIND_HEXU);
                    state_next = (s_tuser > KIND_HEXU) ? ST_EMIT : ST_PREP;
                end
            end
            ST_PREP:
            begin
                unique case (size_reg)
                    SIZE_32:
                    begin
                        masked = {32'd0, mag_reg[31:0]};
                        sbit = mag_reg[31];
                    end
                    SIZE_16:
                    begin
                        masked = {48'd0, mag_reg[15:0]};
                        sbit = mag_reg[15];
                    end
                    default:
                    begin
                        masked = mag_reg;
                        sbit = mag_reg[63];
                    end
                endcase
                neg_next = (kind_reg == KIND_SDEC) && sbit;
                nz_next  = (masked != 64'd0);
                if ((kind_reg == KIND_SDEC) && sbit)
                begin
                    // negate within the kept size
                    unique case (size_reg)
                        SIZE_32: mag_next = {32'd0, 32'(~masked[31:0] + 32'd1)};
                        SIZE_16: mag_next = {48'd0, 16'(~masked[15:0] + 16'd1)};
                        default: mag_next = ~masked + 64'd1;
                    endcase
                end
                else
                    mag_next = masked;
                if (hasp_reg && prec_reg == '0 && masked == 64'd0)
                    state_next = ST_PLAN;
                else
                    state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_ctrl.start = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    dig_we = 1'b1;
                    if (ndig_reg == '0)
                        zfirst_next = (div_rem == 4'd0);
                    ndig_next = ndig_reg + DIG_W'(1);
                    mag_next  = div_quot;
                    if (div_quot != 64'd0 && ndig_reg != DIG_W'(NDIG_MAX - 1))
                        state_next = ST_DIV_GO;
                    else
                        state_next = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                ndw = CW'(ndig_reg);
                zeros = (hasp_reg && prec_reg > ndw) ? prec_reg - ndw : '0;
                if (kind_reg == KIND_OCT && alt_reg && zeros == '0
                    && !(ndig_reg == DIG_W'(1) && zfirst_reg))
                    zeros = CW'(1);
                pre1_next = (kind_reg == KIND_HEXL) ? CH_X_LO : CH_X_UP;
                if (kind_reg == KIND_SDEC)
                begin
                    plen = (neg_reg || fsign_reg || ssign_reg) ? CW'(1) : '0;
                    pre0_next = neg_reg ? CH_MINUS : (fsign_reg ? CH_PLUS : CH_SPACE);
                end
                else
                begin
                    plen = ((kind_reg == KIND_HEXL || kind_reg == KIND_HEXU)
                            && alt_reg && nz_reg) ? CW'(2) : '0;
                    pre0_next = CH_ZERO;
                end
                body = plen + zeros + ndw;
                pad  = (width_reg > body) ? width_reg - body : '0;
                zp   = !left_reg && zpad_reg && !hasp_reg;
                s1   = (!left_reg && !zp) ? pad : '0;
                s3   = zp ? pad : '0;
                s6   = left_reg ? pad : '0;
                e1_next = s1;
                e2_next = s1 + plen;
                e4_next = s1 + plen + s3 + zeros;
                e5_next = s1 + plen + s3 + zeros + ndw;
                e6_next = s1 + plen + s3 + zeros + ndw + s6;
                empty_next = ((s1 + plen + s3 + zeros + ndw + s6) == '0);
                dptr_next  = ndig_reg - DIG_W'(1);
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    if (empty_reg)
                    begin
                        m_tdata_next = 8'd0;
                        m_tuser_next = 1'b0;
                        m_tlast_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        pw = CW'(pos_reg);
                        m_tuser_next = 1'b1;
                        priority if (pw < e1_reg)
                            m_tdata_next = CH_SPACE;
                        else if (pw < e2_reg)
                            m_tdata_next = (pw == e1_reg) ? pre0_reg : pre1_reg;
                        else if (pw < e4_reg)
                            m_tdata_next = CH_ZERO;
                        else if (pw < e5_reg)
                        begin
                            m_tdata_next = dig_reg[dptr_reg];
                            dptr_next = dptr_reg - DIG_W'(1);
                        end
                        else
                            m_tdata_next = CH_SPACE;
                        m_tlast_next = (pw == e6_reg - CW'(1))
                                       || (pos_reg == POS_W'(OUT_LIMIT - 1));
                        pos_next = pos_reg + POS_W'(1);
                        if (m_tlast_next)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            ndig_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            ndig_reg     <= ndig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        mag_reg    <= mag_next;
        size_reg   <= size_next;
        left_reg   <= left_next;
        fsign_reg  <= fsign_next;
        ssign_reg  <= ssign_next;
        zpad_reg   <= zpad_next;
        alt_reg    <= alt_next;
        hasp_reg   <= hasp_next;
        width_reg  <= width_next;
        prec_reg   <= prec_next;
        neg_reg    <= neg_next;
        nz_reg     <= nz_next;
        zfirst_reg <= zfirst_next;
        empty_reg  <= empty_next;
        dptr_reg   <= dptr_next;
        pos_reg    <= pos_next;
        pre0_reg   <= pre0_next;
        pre1_reg   <= pre1_next;
        e1_reg <= e1_next; e2_reg <= e2_next;
        e4_reg <= e4_next; e5_reg <= e5_next; e6_reg <= e6_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
        if (dig_we)
            dig_reg[ndig_reg] <= dig_char;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `ASSERT_ALWAYS(a_empty_is_last, !(m_tvalid && !m_tuser) || m_tlast)
    `ASSERT_ALWAYS(a_digit_bound, ndig_reg <= DIG_W'(NDIG_MAX))

endmodule
